/* sv/tlpt_pkg.sv */
// Shared types, codes and microcode program for the two-level page table unit.
// No dependencies; used by tlpt_sequencer and two_level_page_table_unit_core.
package tlpt_pkg;

   // Request and status codes
   localparam logic [1:0] REQ_MAP          = 2'd0;
   localparam logic [1:0] REQ_UNMAP        = 2'd1;
   localparam logic [1:0] REQ_XLATE        = 2'd2;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT    = 2'd1;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd2;

   // Index width of a directory and of a page table
   localparam int ENTRY_W = 10;

   // Page table entry flag bits
   localparam int PTE_PRESENT_BIT = 0;
   localparam int PTE_USER_BIT    = 2;

   // Microcode step addresses
   typedef logic [3:0] step_type;

   localparam step_type STEP_CLR_DIR        = 4'd0;
   localparam step_type STEP_IDLE           = 4'd1;
   localparam step_type STEP_DECODE         = 4'd2;
   localparam step_type STEP_MAP            = 4'd3;
   localparam step_type STEP_MAP_CHK        = 4'd4;
   localparam step_type STEP_ALLOC          = 4'd5;
   localparam step_type STEP_TBL_CLR        = 4'd6;
   localparam step_type STEP_MAP_WR         = 4'd7;
   localparam step_type STEP_UNMAP          = 4'd8;
   localparam step_type STEP_UNMAP_WR       = 4'd9;
   localparam step_type STEP_XLATE          = 4'd10;
   localparam step_type STEP_XLATE_RSP      = 4'd11;
   localparam step_type STEP_RSP_DONE       = 4'd12;
   localparam step_type STEP_RSP_NO_SLOT    = 4'd13;
   localparam step_type STEP_RSP_NOT_MAPPED = 4'd14;

   // Datapath actions, one per control word
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_DIR_CLR,
      ACT_LATCH,
      ACT_SLOT_LD,
      ACT_ALLOC,
      ACT_TBL_CLR,
      ACT_MAP_WR,
      ACT_UNMAP_WR,
      ACT_RSP_DONE,
      ACT_RSP_NO_SLOT,
      ACT_RSP_NOT_MAPPED,
      ACT_RSP_XLATE
   } act_type;

   // Branch conditions: taken -> target, else next step; dispatch by req type
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_PRESENT,
      COND_ABSENT,
      COND_POOL_FULL,
      COND_SWEEP_MORE,
      COND_DISPATCH
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   // Status flags from the datapath to the sequencer
   typedef struct packed {
      logic       start;
      logic       present;
      logic       pool_full;
      logic       sweep_more;
      logic [1:0] req_type;
   } seq_flags_type;

   // Control store
   function automatic ucode_word_type ucode_rom(step_type step);
      ucode_word_type w;
      w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_CLR_DIR:        w = '{ACT_DIR_CLR,        COND_SWEEP_MORE, STEP_CLR_DIR};
         STEP_IDLE:           w = '{ACT_LATCH,          COND_NO_START,   STEP_IDLE};
         STEP_DECODE:         w = '{ACT_SLOT_LD,        COND_DISPATCH,   STEP_IDLE};
         STEP_MAP:            w = '{ACT_NONE,           COND_PRESENT,    STEP_MAP_WR};
         STEP_MAP_CHK:        w = '{ACT_NONE,           COND_POOL_FULL,  STEP_RSP_NO_SLOT};
         STEP_ALLOC:          w = '{ACT_ALLOC,          COND_NEVER,      STEP_IDLE};
         STEP_TBL_CLR:        w = '{ACT_TBL_CLR,        COND_SWEEP_MORE, STEP_TBL_CLR};
         STEP_MAP_WR:         w = '{ACT_MAP_WR,         COND_ALWAYS,     STEP_RSP_DONE};
         STEP_UNMAP:          w = '{ACT_NONE,           COND_ABSENT,     STEP_RSP_NOT_MAPPED};
         STEP_UNMAP_WR:       w = '{ACT_UNMAP_WR,       COND_ALWAYS,     STEP_RSP_DONE};
         STEP_XLATE:          w = '{ACT_NONE,           COND_ABSENT,     STEP_RSP_NOT_MAPPED};
         STEP_XLATE_RSP:      w = '{ACT_RSP_XLATE,      COND_ALWAYS,     STEP_IDLE};
         STEP_RSP_DONE:       w = '{ACT_RSP_DONE,       COND_ALWAYS,     STEP_IDLE};
         STEP_RSP_NO_SLOT:    w = '{ACT_RSP_NO_SLOT,    COND_ALWAYS,     STEP_IDLE};
         STEP_RSP_NOT_MAPPED: w = '{ACT_RSP_NOT_MAPPED, COND_ALWAYS,     STEP_IDLE};
         default:             w = '{ACT_NONE,           COND_ALWAYS,     STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* sv/two_level_page_table_unit_core.sv */
// Two-level page table unit: directory and table memories, datapath, responses.
// Depends on tlpt_pkg and tlpt_sequencer.
//
//  channel   ports                                              handshake
//  request   req_type, req_virt_addr, req_frame_addr,           start && !busy
//            req_page_flags
//  response  rsp_phys_addr, rsp_status                          rsp_valid, one cycle
//
// rsp_valid is registered from the response step: translate reads the directory entry,
// then the table entry; misses on an absent directory entry answer after the directory
// check; unmap and map into a present entry write first; a refused map checks the pool;
// a map that allocates a table first runs a clearing sweep over the table memory port.
// After reset, busy stays high while the directory is cleared.
// Reset is synchronous; the response side cannot stall, so rsp_valid is a
// single-cycle strobe and the next request is taken the cycle it is shown.
module two_level_page_table_unit_core #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_frame_addr,
   input  logic [11:0] req_page_flags,
   output logic        rsp_valid,
   output logic [31:0] rsp_phys_addr,
   output logic [1:0]  rsp_status
);

   localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int USED_W    = $clog2(TABLE_SLOTS + 1);
   localparam int DIR_W     = SLOT_W + 2;
   localparam int DIR_DEPTH = 1 << tlpt_pkg::ENTRY_W;
   localparam int TBL_DEPTH = TABLE_SLOTS * DIR_DEPTH;
   localparam int TADDR_W   = $clog2(TBL_DEPTH);
   localparam int DIR_P     = 0;
   localparam int DIR_U     = 1;

   tlpt_pkg::ucode_word_type ctrl;
   tlpt_pkg::seq_flags_type  flags;

   // Request holding registers
   logic [1:0]  type_ff;
   logic [31:0] virt_ff;
   logic [19:0] frame_ff;
   logic [11:0] flags_ff;

   // Datapath registers
   logic [SLOT_W-1:0]           slot_ff;
   logic [USED_W-1:0]           used_ff;
   logic [tlpt_pkg::ENTRY_W-1:0] cnt_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_phys_ff;
   logic [1:0]                  rsp_status_ff;

   // Memories
   logic [DIR_W-1:0] dir_mem [DIR_DEPTH];
   logic [31:0]      tbl_mem [TBL_DEPTH];
   logic [DIR_W-1:0] dir_rdata_ff;
   logic [31:0]      tbl_rdata_ff;

   logic                        dir_we;
   logic [tlpt_pkg::ENTRY_W-1:0] dir_waddr;
   logic [DIR_W-1:0]            dir_wdata;
   logic [tlpt_pkg::ENTRY_W-1:0] dir_raddr;
   logic                        tbl_we;
   logic [TADDR_W-1:0]          tbl_waddr;
   logic [31:0]                 tbl_wdata;
   logic [TADDR_W-1:0]          tbl_raddr;
   logic                        accept;
   logic                        user_req;

   tlpt_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // Handshake: the idle step is the only one that takes a request
   assign busy   = (ctrl.act != tlpt_pkg::ACT_LATCH);
   assign accept = start && !busy;

   // Flags for the branch logic
   assign flags.start      = start;
   assign flags.present    = dir_rdata_ff[DIR_P];
   assign flags.pool_full  = (used_ff >= USED_W'(TABLE_SLOTS));
   assign flags.sweep_more = (cnt_ff != '1);
   assign flags.req_type   = type_ff;

   assign user_req = flags_ff[tlpt_pkg::PTE_USER_BIT];

   // Directory port control
   always_comb begin
      dir_raddr = (ctrl.act == tlpt_pkg::ACT_LATCH) ? req_virt_addr[31:22] : virt_ff[31:22];
      dir_we    = 1'b0;
      dir_waddr = virt_ff[31:22];
      dir_wdata = '0;
      case (ctrl.act)
         tlpt_pkg::ACT_DIR_CLR: begin
            dir_we    = 1'b1;
            dir_waddr = cnt_ff;
         end
         tlpt_pkg::ACT_ALLOC: begin
            dir_we    = 1'b1;
            dir_wdata = {SLOT_W'(used_ff), user_req, 1'b1};
         end
         tlpt_pkg::ACT_MAP_WR: begin
            dir_we    = 1'b1;
            dir_wdata = {slot_ff, dir_rdata_ff[DIR_U] | user_req, 1'b1};
         end
         default: begin
            dir_we = 1'b0;
         end
      endcase
   end

   // Table port control
   always_comb begin
      tbl_raddr = TADDR_W'({slot_ff, virt_ff[21:12]});
      tbl_we    = 1'b0;
      tbl_waddr = TADDR_W'({slot_ff, virt_ff[21:12]});
      tbl_wdata = '0;
      case (ctrl.act)
         tlpt_pkg::ACT_TBL_CLR: begin
            tbl_we    = 1'b1;
            tbl_waddr = TADDR_W'({slot_ff, cnt_ff});
         end
         tlpt_pkg::ACT_MAP_WR: begin
            tbl_we    = 1'b1;
            tbl_wdata = {frame_ff, flags_ff};
         end
         tlpt_pkg::ACT_UNMAP_WR: begin
            tbl_we = 1'b1;
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   // Directory memory, registered read
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rdata_ff <= dir_mem[dir_raddr];
   end

   // Page table memory, registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rdata_ff <= tbl_mem[tbl_raddr];
   end

   // Hold the request
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         virt_ff  <= req_virt_addr;
         frame_ff <= req_frame_addr[31:12];
         flags_ff <= req_page_flags;
      end
   end

   // Slot pointer
   always_ff @(posedge clock) begin
      if (ctrl.act == tlpt_pkg::ACT_SLOT_LD) begin
         slot_ff <= dir_rdata_ff[DIR_W-1:2];
      end else if (ctrl.act == tlpt_pkg::ACT_ALLOC) begin
         slot_ff <= SLOT_W'(used_ff);
      end
   end

   // Sweep counter and slot pool
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         used_ff <= '0;
      end else begin
         case (ctrl.act)
            tlpt_pkg::ACT_DIR_CLR, tlpt_pkg::ACT_TBL_CLR: begin
               cnt_ff <= cnt_ff + tlpt_pkg::ENTRY_W'(1);
            end
            tlpt_pkg::ACT_ALLOC: begin
               cnt_ff  <= '0;
               used_ff <= used_ff + USED_W'(1);
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (ctrl.act == tlpt_pkg::ACT_RSP_DONE)
                      || (ctrl.act == tlpt_pkg::ACT_RSP_NO_SLOT)
                      || (ctrl.act == tlpt_pkg::ACT_RSP_NOT_MAPPED)
                      || (ctrl.act == tlpt_pkg::ACT_RSP_XLATE);
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      case (ctrl.act)
         tlpt_pkg::ACT_RSP_DONE: begin
            rsp_phys_ff   <= '0;
            rsp_status_ff <= tlpt_pkg::STATUS_DONE;
         end
         tlpt_pkg::ACT_RSP_NO_SLOT: begin
            rsp_phys_ff   <= '0;
            rsp_status_ff <= tlpt_pkg::STATUS_NO_SLOT;
         end
         tlpt_pkg::ACT_RSP_NOT_MAPPED: begin
            rsp_phys_ff   <= '0;
            rsp_status_ff <= tlpt_pkg::STATUS_NOT_MAPPED;
         end
         tlpt_pkg::ACT_RSP_XLATE: begin
            if (tbl_rdata_ff[tlpt_pkg::PTE_PRESENT_BIT]) begin
               rsp_phys_ff   <= {tbl_rdata_ff[31:12], virt_ff[11:0]};
               rsp_status_ff <= tlpt_pkg::STATUS_DONE;
            end else begin
               rsp_phys_ff   <= '0;
               rsp_status_ff <= tlpt_pkg::STATUS_NOT_MAPPED;
            end
         end
         default: begin
            rsp_phys_ff   <= rsp_phys_ff;
            rsp_status_ff <= rsp_status_ff;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_phys_ff;
   assign rsp_status    = rsp_status_ff;

   // Every response step produces exactly one strobe
   a_rsp_follows_step: assert property (@(posedge clock) disable iff (reset)
      ((ctrl.act == tlpt_pkg::ACT_RSP_DONE) || (ctrl.act == tlpt_pkg::ACT_RSP_NO_SLOT)
       || (ctrl.act == tlpt_pkg::ACT_RSP_NOT_MAPPED)
       || (ctrl.act == tlpt_pkg::ACT_RSP_XLATE)) |=> rsp_valid)
      else $error("response step without strobe");

   // The block is back in idle whenever a response is shown
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   // The slot pool never overflows
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(TABLE_SLOTS))
      else $error("slot pool overflow");

   // Error responses carry a zero address
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != tlpt_pkg::STATUS_DONE)) |-> (rsp_phys_addr == '0))
      else $error("error response with nonzero address");

endmodule

/* sv/tlpt_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on tlpt_pkg for the control word, flags and program.
module tlpt_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  tlpt_pkg::seq_flags_type flags,
   output tlpt_pkg::ucode_word_type ctrl
);

   tlpt_pkg::step_type pc_ff;
   tlpt_pkg::step_type pc_in;
   tlpt_pkg::step_type dispatch_step;
   logic               taken;

   // Fetch the current control word
   always_comb begin
      ctrl = tlpt_pkg::ucode_rom(pc_ff);
   end

   // Pick the first step of each request type
   always_comb begin
      unique case (flags.req_type)
         tlpt_pkg::REQ_MAP:   dispatch_step = tlpt_pkg::STEP_MAP;
         tlpt_pkg::REQ_UNMAP: dispatch_step = tlpt_pkg::STEP_UNMAP;
         tlpt_pkg::REQ_XLATE: dispatch_step = tlpt_pkg::STEP_XLATE;
         default:             dispatch_step = tlpt_pkg::STEP_RSP_DONE;
      endcase
   end

   // Evaluate the branch condition
   always_comb begin
      unique case (ctrl.cond)
         tlpt_pkg::COND_NEVER:      taken = 1'b0;
         tlpt_pkg::COND_ALWAYS:     taken = 1'b1;
         tlpt_pkg::COND_NO_START:   taken = !flags.start;
         tlpt_pkg::COND_PRESENT:    taken = flags.present;
         tlpt_pkg::COND_ABSENT:     taken = !flags.present;
         tlpt_pkg::COND_POOL_FULL:  taken = flags.pool_full;
         tlpt_pkg::COND_SWEEP_MORE: taken = flags.sweep_more;
         tlpt_pkg::COND_DISPATCH:   taken = 1'b1;
         default:                   taken = 1'b0;
      endcase
   end

   // Next step: dispatch, branch target or fall through
   always_comb begin
      if (ctrl.cond == tlpt_pkg::COND_DISPATCH) begin
         pc_in = dispatch_step;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   // Advance the step counter; reset starts the directory clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= tlpt_pkg::STEP_CLR_DIR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
